/* src/vas_pkg.sv */
// vas_pkg: shared types and constants of the voice allocator
// depends on nothing; used by voice_allocator_oldest_steal_top and vas_age_unit by scoped names
`default_nettype none

package vas_pkg;

    // field widths of the stream words
    localparam int ACTION_W    = 2;
    localparam int NOTE_W      = 7;
    localparam int VIN_W       = 6;
    localparam int VOICE_OUT_W = 6;
    localparam int STAMP_W     = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISHED = 2'd2;

    // result of the shared age / note compare unit
    typedef struct packed {
        logic               better;
        logic               note_match;
        logic [STAMP_W-1:0] age;
    } t_cmp_res;

endpackage

`default_nettype wire

/* src/voice_allocator_oldest_steal_top.sv */
// voice_allocator_oldest_steal_top: polyphonic voice allocator, oldest-note stealing
// depends on vas_pkg, vas_ram, vas_age_unit
`default_nettype none

// A note-on takes the lowest free voice and, when one is free, goes from
// idle straight to the write state. When every voice is busy, and for
// every note-off, a sequencer walks the voice table one entry per cycle
// through a single read port of the note/stamp ram and one shared age/note
// compare unit. After the scan a state picks the result and, for a stolen
// note-on, the write state writes the table and gives the result.
// A voice-finished word or an unused action code has its result registered
// on acceptance. Only one word is in work at a time: o_s_tready is high
// while the sequencer is idle and no result waits on the output. Exactly one
// result word comes out per input word. Stealing prefers the oldest releasing
// voice, then the oldest active one; the lowest index wins ties, and age is
// the 32-bit note-on counter minus the stamp, modulo 2^32.

module voice_allocator_oldest_steal_top #(
    parameter int VOICES = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input word, tdata from bit 0: action[1:0], note[8:2], voice_in[14:9], zero
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [vas_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // result word, tdata from bit 0: voice[5:0], found[6], stolen[7]
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic      [vas_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int VW    = $clog2(VOICES);
    localparam int CW    = $clog2(VOICES + 1);
    localparam int RAM_W = vas_pkg::NOTE_W + vas_pkg::STAMP_W;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0] r_state, n_state;

    // input word fields
    logic [vas_pkg::ACTION_W-1:0] in_action;
    logic [vas_pkg::NOTE_W-1:0]   in_note;
    logic [vas_pkg::VIN_W-1:0]    in_vin;
    logic                         s_fire;

    assign in_action = i_s_tdata[1:0];
    assign in_note   = i_s_tdata[8:2];
    assign in_vin    = i_s_tdata[14:9];
    assign s_fire    = i_s_tvalid && o_s_tready;

    // voice table flags and note-on counter
    logic [VOICES-1:0]           r_active;
    logic [VOICES-1:0]           r_releasing;
    logic [vas_pkg::STAMP_W-1:0] r_counter;

    // word in work
    logic [vas_pkg::ACTION_W-1:0] r_action;
    logic [vas_pkg::NOTE_W-1:0]   r_note;
    logic [VW-1:0]                r_voice;
    logic                         r_stolen;

    // scan bookkeeping
    logic [CW-1:0]               r_cnt;
    logic                        r_pv;
    logic [VW-1:0]               r_pidx;
    logic                        r_rel_ok, r_act_ok, r_hit;
    logic [vas_pkg::STAMP_W-1:0] r_rel_age, r_act_age;
    logic [VW-1:0]               r_rel_idx, r_act_idx, r_hit_idx;

    // output register
    logic                           r_m_tvalid;
    logic [vas_pkg::OUT_TDATA_W-1:0] r_m_tdata;

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_s_tready = (r_state == S_IDLE) && !r_m_tvalid;

    // lowest free voice
    logic          any_free;
    logic [VW-1:0] free_idx;

    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                any_free = 1'b1;
                free_idx = VW'(i);
            end
        end
    end

    // voice_in range check, widened so 64 voices still compares right
    logic vin_ok;
    assign vin_ok = ({1'b0, in_vin} < 7'(VOICES));

    // note/stamp ram: written on note-on, read by the scan
    logic             ram_we;
    logic [RAM_W-1:0] ram_rdata;
    logic [VW-1:0]    ram_raddr;

    assign ram_we    = (r_state == S_WRITE);
    assign ram_raddr = r_cnt[VW-1:0];

    vas_ram #(
        .WIDTH (RAM_W),
        .DEPTH (VOICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_voice),
        .i_wdata ({r_note, r_counter}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared compare unit, best age taken from the class of the scanned voice
    logic              p_rel;
    vas_pkg::t_cmp_res cmp;

    assign p_rel = r_releasing[r_pidx];

    vas_age_unit u_age (
        .i_counter    (r_counter),
        .i_stamp      (ram_rdata[vas_pkg::STAMP_W-1:0]),
        .i_best_age   (p_rel ? r_rel_age : r_act_age),
        .i_best_ok    (p_rel ? r_rel_ok : r_act_ok),
        .i_note       (r_note),
        .i_entry_note (ram_rdata[RAM_W-1:vas_pkg::STAMP_W]),
        .o_res        (cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    if (in_action == vas_pkg::ACT_NOTE_ON) begin
                        n_state = any_free ? S_WRITE : S_SCAN;
                    end else if (in_action == vas_pkg::ACT_NOTE_OFF) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt == CW'(VOICES)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = (r_action == vas_pkg::ACT_NOTE_ON) ? S_WRITE : S_IDLE;
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_releasing <= '0;
            r_counter   <= '0;
            r_m_tvalid  <= 1'b0;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_m_tvalid && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_pv  <= 1'b0;
                    if (s_fire) begin
                        if (in_action == vas_pkg::ACT_FINISHED) begin
                            if (vin_ok) begin
                                r_active[in_vin[VW-1:0]]    <= 1'b0;
                                r_releasing[in_vin[VW-1:0]] <= 1'b0;
                            end
                            r_m_tvalid <= 1'b1;
                        end else if (in_action != vas_pkg::ACT_NOTE_ON &&
                                     in_action != vas_pkg::ACT_NOTE_OFF) begin
                            r_m_tvalid <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    // issue the next read while the previous entry is compared
                    if (r_cnt != CW'(VOICES)) begin
                        r_cnt <= r_cnt + CW'(1);
                        r_pv  <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                end
                S_FIN: begin
                    if (r_action == vas_pkg::ACT_NOTE_OFF) begin
                        if (r_hit) begin
                            r_releasing[r_hit_idx] <= 1'b1;
                        end
                        r_m_tvalid <= 1'b1;
                    end
                end
                S_WRITE: begin
                    r_active[r_voice]    <= 1'b1;
                    r_releasing[r_voice] <= 1'b0;
                    r_counter            <= r_counter + 32'd1;
                    r_m_tvalid           <= 1'b1;
                end
                default: begin
                    r_pv <= 1'b0;
                end
            endcase
        end
    end

    // payload and scan trackers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rel_ok <= 1'b0;
                r_act_ok <= 1'b0;
                r_hit    <= 1'b0;
                if (s_fire) begin
                    r_action <= in_action;
                    r_note   <= in_note;
                    r_voice  <= free_idx;
                    r_stolen <= 1'b0;
                    // finished voice or unused code: result straight out
                    if (in_action == vas_pkg::ACT_FINISHED && vin_ok) begin
                        r_m_tdata <= {1'b0, 1'b1, in_vin};
                    end else begin
                        r_m_tdata <= '0;
                    end
                end
            end
            S_SCAN: begin
                r_pidx <= r_cnt[VW-1:0];
                if (r_pv) begin
                    if (r_action == vas_pkg::ACT_NOTE_ON) begin
                        // every voice is active here, so all stamps are written
                        if (cmp.better) begin
                            if (p_rel) begin
                                r_rel_ok  <= 1'b1;
                                r_rel_age <= cmp.age;
                                r_rel_idx <= r_pidx;
                            end else begin
                                r_act_ok  <= 1'b1;
                                r_act_age <= cmp.age;
                                r_act_idx <= r_pidx;
                            end
                        end
                    end else if (!r_hit && r_active[r_pidx] && cmp.note_match) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_pidx;
                    end
                end
            end
            S_FIN: begin
                if (r_action == vas_pkg::ACT_NOTE_ON) begin
                    r_voice  <= r_rel_ok ? r_rel_idx : r_act_idx;
                    r_stolen <= 1'b1;
                end else if (r_hit) begin
                    r_m_tdata <= {1'b0, 1'b1, vas_pkg::VOICE_OUT_W'(r_hit_idx)};
                end else begin
                    r_m_tdata <= '0;
                end
            end
            S_WRITE: begin
                r_m_tdata <= {r_stolen, 1'b1, vas_pkg::VOICE_OUT_W'(r_voice)};
            end
            default: begin
                r_hit <= 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/vas_ram.sv */
// vas_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module vas_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/vas_age_unit.sv */
// vas_age_unit: shared compare unit used once per scanned voice
// computes wrapped age, compares against the running best, matches the note
// depends on vas_pkg
`default_nettype none

module vas_age_unit (
    input  wire logic [vas_pkg::STAMP_W-1:0] i_counter,
    input  wire logic [vas_pkg::STAMP_W-1:0] i_stamp,
    input  wire logic [vas_pkg::STAMP_W-1:0] i_best_age,
    input  wire logic                        i_best_ok,
    input  wire logic [vas_pkg::NOTE_W-1:0]  i_note,
    input  wire logic [vas_pkg::NOTE_W-1:0]  i_entry_note,
    output vas_pkg::t_cmp_res                o_res
);

    logic [vas_pkg::STAMP_W-1:0] age;

    // age wraps modulo 2^32 with the counter
    assign age              = i_counter - i_stamp;
    assign o_res.age        = age;
    assign o_res.better     = !i_best_ok || (age > i_best_age);
    assign o_res.note_match = (i_note == i_entry_note);

endmodule

`default_nettype wire

/* verif/tb_voice_allocator_oldest_steal_top.sv */
`timescale 1ns / 1ps
// tb_voice_allocator_oldest_steal_top: self-checking bench for the voice allocator,
// with a stream driver, a result monitor and a voice table predictor
// depends on vas_pkg and voice_allocator_oldest_steal_top from src

module tb_voice_allocator_oldest_steal_top;

    localparam int NUM_VOICES   = 16;
    localparam logic [vas_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1200;
    localparam int CALM_TAIL    = 150;   // last words go without idling
    localparam int DRAIN_CYCLES = 40;    // longer than the longest scan

    // input word, packed so that action sits in the lowest bits
    typedef struct packed {
        logic [vas_pkg::VIN_W-1:0]    voice_in;
        logic [vas_pkg::NOTE_W-1:0]   note;
        logic [vas_pkg::ACTION_W-1:0] action;
    } t_note_event;

    typedef struct {
        logic [vas_pkg::VOICE_OUT_W-1:0] voice;
        logic                            found;
        logic                            stolen;
    } t_alloc_result;

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [vas_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [vas_pkg::OUT_TDATA_W-1:0] m_tdata;

    voice_allocator_oldest_steal_top #(
        .VOICES (NUM_VOICES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // voice table as the predictor sees it
    logic                          voice_active    [NUM_VOICES];
    logic                          voice_releasing [NUM_VOICES];
    logic [vas_pkg::NOTE_W-1:0]    voice_note      [NUM_VOICES];
    logic [vas_pkg::STAMP_W-1:0]   voice_stamp     [NUM_VOICES];
    logic [vas_pkg::STAMP_W-1:0]   note_on_count;

    t_note_event   event_queue[$];
    t_alloc_result expected_results[$];
    int            error_count  = 0;
    int            result_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d want %0d", result_count, what, got, want);
        error_count++;
    endtask

    // updates the voice table for one word and returns the result it should give
    function automatic t_alloc_result apply_event(input t_note_event ev);
        t_alloc_result               res;
        int                          i;
        int                          pick;
        int                          rel_idx;
        int                          act_idx;
        logic                        rel_ok;
        logic                        act_ok;
        logic [vas_pkg::STAMP_W-1:0] age;
        logic [vas_pkg::STAMP_W-1:0] rel_age;
        logic [vas_pkg::STAMP_W-1:0] act_age;
        res     = '{voice: '0, found: 1'b0, stolen: 1'b0};
        pick    = -1;
        rel_idx = 0;
        act_idx = 0;
        rel_ok  = 1'b0;
        act_ok  = 1'b0;
        rel_age = '0;
        act_age = '0;
        case (ev.action)
            vas_pkg::ACT_NOTE_ON: begin
                for (i = 0; i < NUM_VOICES; i++) begin
                    if (!voice_active[i] && pick < 0) pick = i;
                end
                if (pick < 0) begin
                    // table full: oldest releasing voice first, then oldest active,
                    // strict compare keeps the lowest index on a tie
                    res.stolen = 1'b1;
                    for (i = 0; i < NUM_VOICES; i++) begin
                        age = note_on_count - voice_stamp[i];
                        if (voice_releasing[i]) begin
                            if (!rel_ok || age > rel_age) begin
                                rel_ok  = 1'b1;
                                rel_age = age;
                                rel_idx = i;
                            end
                        end else if (!act_ok || age > act_age) begin
                            act_ok  = 1'b1;
                            act_age = age;
                            act_idx = i;
                        end
                    end
                    pick = rel_ok ? rel_idx : act_idx;
                end
                voice_active[pick]    = 1'b1;
                voice_releasing[pick] = 1'b0;
                voice_note[pick]      = ev.note;
                voice_stamp[pick]     = note_on_count;
                note_on_count         = note_on_count + vas_pkg::STAMP_W'(1);
                res.voice             = pick[vas_pkg::VOICE_OUT_W-1:0];
                res.found             = 1'b1;
            end
            vas_pkg::ACT_NOTE_OFF: begin
                // an already releasing voice still matches
                for (i = 0; i < NUM_VOICES; i++) begin
                    if (pick < 0 && voice_active[i] && voice_note[i] == ev.note) pick = i;
                end
                if (pick >= 0) begin
                    voice_releasing[pick] = 1'b1;
                    res.voice             = pick[vas_pkg::VOICE_OUT_W-1:0];
                    res.found             = 1'b1;
                end
            end
            vas_pkg::ACT_FINISHED: begin
                if (ev.voice_in < NUM_VOICES) begin
                    voice_active[ev.voice_in]    = 1'b0;
                    voice_releasing[ev.voice_in] = 1'b0;
                    res.voice                    = ev.voice_in;
                    res.found                    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // driver: presents queued words, predicts each one as it is taken
    int src_gap = 0;

    always @(posedge i_clk) begin
        t_note_event ev;
        logic        take;
        logic        next_valid;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  = 0;
        end else begin
            take       = s_tvalid && s_tready;
            next_valid = s_tvalid;
            if (take) begin
                expected_results.push_back(apply_event(t_note_event'(s_tdata[14:0])));
                if (event_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 17);
            end
            if (!s_tvalid || take) begin
                next_valid = 1'b0;
                if (src_gap > 0) begin
                    src_gap--;
                end else if (event_queue.size() > 0) begin
                    ev         = event_queue.pop_front();
                    next_valid = 1'b1;
                    s_tdata    <= {1'b0, ev};
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // monitor: random back-pressure, compares each result word with the oldest prediction
    int sink_stall = 0;

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word, tdata", int'(m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[5:0] !== want.voice)
                        report_mismatch("voice", int'(m_tdata[5:0]), int'(want.voice));
                    if (m_tdata[6] !== want.found)
                        report_mismatch("found", int'(m_tdata[6]), int'(want.found));
                    if (m_tdata[7] !== want.stolen)
                        report_mismatch("stolen", int'(m_tdata[7]), int'(want.stolen));
                end
                result_count++;
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if (event_queue.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                sink_stall = $urandom_range(0, 16);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic t_note_event make_event(input logic [vas_pkg::ACTION_W-1:0] act,
                                               input int note, input int vin);
        t_note_event ev;
        ev.action   = act;
        ev.note     = note[vas_pkg::NOTE_W-1:0];
        ev.voice_in = vin[vas_pkg::VIN_W-1:0];
        return ev;
    endfunction

    // stimulus and end of run
    initial begin
        logic [vas_pkg::NOTE_W-1:0] recent_notes[$];
        logic [vas_pkg::NOTE_W-1:0] pool_base;
        int                         made;
        int                         pick;
        int                         weight_on;
        int                         weight_off;
        int                         weight_fin;
        int                         k;

        for (k = 0; k < NUM_VOICES; k++) begin
            voice_active[k]    = 1'b0;
            voice_releasing[k] = 1'b0;
            voice_note[k]      = '0;
            voice_stamp[k]     = '0;
        end
        note_on_count = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-table corner cases
        event_queue.push_back(make_event(vas_pkg::ACT_NOTE_OFF, 5, 0));   // no match
        event_queue.push_back(make_event(vas_pkg::ACT_FINISHED, 0, 0));   // finish an idle voice
        event_queue.push_back(make_event(ACT_UNUSED, 127, 63));           // ignored code
        event_queue.push_back(make_event(vas_pkg::ACT_FINISHED, 0, 63));  // index out of range
        event_queue.push_back(make_event(vas_pkg::ACT_FINISHED, 127, NUM_VOICES));
        // fill every voice, extreme notes first
        event_queue.push_back(make_event(vas_pkg::ACT_NOTE_ON, 0, 0));
        event_queue.push_back(make_event(vas_pkg::ACT_NOTE_ON, 127, 63));
        for (k = 2; k < NUM_VOICES; k++)
            event_queue.push_back(make_event(vas_pkg::ACT_NOTE_ON, k * 7, 42));
        // release the same note twice, it stays releasing
        event_queue.push_back(make_event(vas_pkg::ACT_NOTE_OFF, 127, 0));
        event_queue.push_back(make_event(vas_pkg::ACT_NOTE_OFF, 127, 0));
        // full table: steal the releasing voice, then the oldest active one
        event_queue.push_back(make_event(vas_pkg::ACT_NOTE_ON, 85, 0));
        event_queue.push_back(make_event(vas_pkg::ACT_NOTE_ON, 42, 0));
        event_queue.push_back(make_event(vas_pkg::ACT_FINISHED, 0, NUM_VOICES - 1));

        // random: phases alternate between a crowded table and a draining one
        made = 0;
        while (made < RANDOM_WORDS) begin
            if ((made / 200) % 2 == 0) begin
                weight_on  = 55;
                weight_off = 25;
                weight_fin = 15;
            end else begin
                weight_on  = 30;
                weight_off = 30;
                weight_fin = 35;
            end
            if (made % 200 == 0) pool_base = vas_pkg::NOTE_W'($urandom_range(0, 103));
            pick = $urandom_range(0, 99);
            if (pick < weight_on) begin
                if ($urandom_range(0, 9) < 7)
                    event_queue.push_back(make_event(vas_pkg::ACT_NOTE_ON,
                        int'(pool_base) + $urandom_range(0, 23), $urandom_range(0, 63)));
                else
                    event_queue.push_back(make_event(vas_pkg::ACT_NOTE_ON,
                        $urandom_range(0, 127), $urandom_range(0, 63)));
                recent_notes.push_back(event_queue[$].note);
                if (recent_notes.size() > 24) void'(recent_notes.pop_front());
                made++;
            end else if (pick < weight_on + weight_off) begin
                if (recent_notes.size() > 0 && $urandom_range(0, 9) < 8)
                    event_queue.push_back(make_event(vas_pkg::ACT_NOTE_OFF,
                        int'(recent_notes[$urandom_range(0, recent_notes.size() - 1)]),
                        $urandom_range(0, 63)));
                else
                    event_queue.push_back(make_event(vas_pkg::ACT_NOTE_OFF,
                        $urandom_range(0, 127), $urandom_range(0, 63)));
                made++;
            end else if (pick < weight_on + weight_off + weight_fin) begin
                if ($urandom_range(0, 99) < 85)
                    event_queue.push_back(make_event(vas_pkg::ACT_FINISHED,
                        $urandom_range(0, 127), $urandom_range(0, NUM_VOICES - 1)));
                else
                    event_queue.push_back(make_event(vas_pkg::ACT_FINISHED,
                        $urandom_range(0, 127), $urandom_range(NUM_VOICES, 63)));
                made++;
            end else begin
                // ignored code, random payload
                event_queue.push_back(make_event(ACT_UNUSED,
                    $urandom_range(0, 127), $urandom_range(0, 63)));
                made++;
            end
        end

        while (event_queue.size() > 0 || s_tvalid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch("results left over", 0, expected_results.size());
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
